// File: rtl/core/slncp_pkg.sv
// Shared constants and character classifiers for the star-letter-number
// command parser. No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package slncp_pkg;

    localparam int DEFAULT_VALUE_BITS = 31;
    localparam int CHAR_BITS          = 8;
    localparam int DIGIT_BITS         = 4;

    localparam logic [CHAR_BITS-1:0] CHAR_STAR = 8'h2A;  // '*'
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;  // '0'
    localparam logic [CHAR_BITS-1:0] CHAR_NINE = 8'h39;  // '9'
    localparam logic [CHAR_BITS-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_D    = 8'h44;
    localparam logic [CHAR_BITS-1:0] CHAR_F    = 8'h46;
    localparam logic [CHAR_BITS-1:0] CHAR_I    = 8'h49;
    localparam logic [CHAR_BITS-1:0] CHAR_P    = 8'h50;
    localparam logic [CHAR_BITS-1:0] CHAR_Q    = 8'h51;
    localparam logic [CHAR_BITS-1:0] CHAR_R    = 8'h52;
    localparam logic [CHAR_BITS-1:0] CHAR_T    = 8'h54;

    function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_cmd_letter(input logic [CHAR_BITS-1:0] c);
        return (c == CHAR_A) || (c == CHAR_F) || (c == CHAR_D) || (c == CHAR_I) ||
               (c == CHAR_P) || (c == CHAR_R) || (c == CHAR_Q) || (c == CHAR_T);
    endfunction

endpackage

// File: rtl/core/slncp_acc.sv
// Decimal digit accumulator: value * 10 + digit with saturation.
// Depends on slncp_pkg for widths.
`timescale 1ns / 1ps

module slncp_acc #(
    parameter int VALUE_BITS = slncp_pkg::DEFAULT_VALUE_BITS
) (
    input  logic [VALUE_BITS-1:0]           i_value,
    input  logic [slncp_pkg::DIGIT_BITS-1:0] i_digit,
    output logic [VALUE_BITS-1:0]           o_value,
    output logic                            o_sat
);

    localparam int WIDE_BITS = VALUE_BITS + 4;

    logic [WIDE_BITS-1:0] w_base;
    logic [WIDE_BITS-1:0] w_sum;
    logic [WIDE_BITS-1:0] w_max;

    // x*10 as x*8 + x*2: one adder tree, no multiplier
    assign w_base = WIDE_BITS'(i_value);
    assign w_max  = WIDE_BITS'({VALUE_BITS{1'b1}});
    assign w_sum  = (w_base << 3) + (w_base << 1) + WIDE_BITS'(i_digit);
    assign o_sat  = (w_sum > w_max);
    assign o_value = o_sat ? {VALUE_BITS{1'b1}} : w_sum[VALUE_BITS-1:0];

endmodule

// File: rtl/core/slncp_fsm.sv
// Parse state machine: phase, pending letter, accumulator and overflow flag.
// Depends on slncp_pkg and slncp_acc.
`timescale 1ns / 1ps

module slncp_fsm #(
    parameter int VALUE_BITS = slncp_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [slncp_pkg::CHAR_BITS-1:0] i_data,
    input  logic                            i_last,
    output logic                            o_emit,
    output logic [slncp_pkg::CHAR_BITS-1:0] o_letter,
    output logic [VALUE_BITS-1:0]           o_value,
    output logic                            o_ovf
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_STAR   = 2'd1,
        PH_LETTER = 2'd2,
        PH_DIGITS = 2'd3
    } t_phase;

    t_phase                            r_phase, n_phase;
    logic [slncp_pkg::CHAR_BITS-1:0]   r_letter, n_letter;
    logic [VALUE_BITS-1:0]             r_acc, n_acc;
    logic                              r_ovf, n_ovf;

    logic [slncp_pkg::CHAR_BITS-1:0]   w_off;
    logic                              w_digit;
    logic [VALUE_BITS-1:0]             w_acc_in;
    logic [VALUE_BITS-1:0]             w_acc_out;
    logic                              w_sat;
    logic                              w_ovf_in;
    logic                              w_fresh;

    assign w_off   = i_data - slncp_pkg::CHAR_ZERO;
    assign w_digit = slncp_pkg::is_digit(i_data);

    // a new digit run starts from zero
    assign w_acc_in = (r_phase == PH_LETTER) ? '0 : r_acc;
    assign w_ovf_in = (r_phase == PH_LETTER) ? 1'b0 : r_ovf;

    slncp_acc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_acc (
        .i_value (w_acc_in),
        .i_digit (w_off[slncp_pkg::DIGIT_BITS-1:0]),
        .o_value (w_acc_out),
        .o_sat   (w_sat)
    );

    always_comb begin
        n_phase  = r_phase;
        n_letter = r_letter;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        o_emit   = 1'b0;
        w_fresh  = 1'b0;
        unique case (r_phase)
            PH_DIGITS, PH_LETTER: begin
                if (w_digit) begin
                    n_acc   = w_acc_out;
                    n_ovf   = w_ovf_in | w_sat;
                    n_phase = PH_DIGITS;
                    o_emit  = i_last;
                end else begin
                    // a non-digit closes a run; it is then parsed afresh
                    o_emit  = (r_phase == PH_DIGITS);
                    w_fresh = 1'b1;
                end
            end
            PH_STAR: begin
                if (slncp_pkg::is_cmd_letter(i_data)) begin
                    n_letter = i_data;
                    n_phase  = PH_LETTER;
                end else begin
                    w_fresh = 1'b1;
                end
            end
            default: begin
                w_fresh = 1'b1;
            end
        endcase
        if (w_fresh) begin
            n_phase = (i_data == slncp_pkg::CHAR_STAR) ? PH_STAR : PH_IDLE;
        end
        if (i_last) begin
            n_phase  = PH_IDLE;
            n_letter = '0;
            n_acc    = '0;
            n_ovf    = 1'b0;
        end
        o_emit = o_emit & i_step;
    end

    // emitted fields: the updated run when a digit ends it, else the stored run
    assign o_letter = r_letter;
    assign o_value  = w_digit ? w_acc_out : r_acc;
    assign o_ovf    = w_digit ? (w_ovf_in | w_sat) : r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_letter <= '0;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_letter <= n_letter;
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> (r_phase == PH_IDLE) && (r_acc == '0) && !r_ovf)
        else $error("last item did not return the parser to idle");

    a_letter_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LETTER || r_phase == PH_DIGITS) |->
            slncp_pkg::is_cmd_letter(r_letter))
        else $error("pending letter outside the command set");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_acc == {VALUE_BITS{1'b1}}))
        else $error("overflow flag set without saturated value");

    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> (r_phase == PH_DIGITS || r_phase == PH_LETTER))
        else $error("command emitted outside a digit run");

endmodule

// File: rtl/core/star_letter_number_command_parser.sv
// Top level of the star-letter-number command parser: input register,
// parse state machine (slncp_fsm) and result register. Depends on slncp_pkg.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------------
//  s (in)   | slave     | tdata[7:0] data_byte, tlast last_byte
//  m (out)  | master    | tdata command_letter, command_value; tuser overflow
//
//  One item is accepted per cycle unless a stalled result fills both registers;
//  a result reaches the master side through the input register, then the
//  result register. The parse state update and the x*10+digit adder are
//  combinational between the two registers.
//  A stalled result holds in the result register while one further item
//  waits in the input register; tready drops only when both are full.
//  i_rst_n is synchronous, active low, and returns the parser to idle.

module star_letter_number_command_parser #(
    parameter int VALUE_BITS = slncp_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave side
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] data_byte
    input  logic                        i_s_tlast,   // last_byte
    // master side
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [((slncp_pkg::CHAR_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0]
                                        o_m_tdata,   // [7:0] command_letter,
                                                     // then command_value,
                                                     // zero padded
    output logic                        o_m_tuser    // value_overflow
);

    localparam int OUT_DATA_BITS = ((slncp_pkg::CHAR_BITS + VALUE_BITS + 7) / 8) * 8;

    logic                            r_in_valid;
    logic [slncp_pkg::CHAR_BITS-1:0] r_in_data;
    logic                            r_in_last;

    logic                            r_out_valid;
    logic [slncp_pkg::CHAR_BITS-1:0] r_out_letter;
    logic [VALUE_BITS-1:0]           r_out_value;
    logic                            r_out_ovf;

    logic                            w_advance;
    logic                            w_step;
    logic                            w_accept;
    logic                            w_emit;
    logic [slncp_pkg::CHAR_BITS-1:0] w_letter;
    logic [VALUE_BITS-1:0]           w_value;
    logic                            w_ovf;

    // result register can take a new value when empty or being drained
    assign w_advance  = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_advance;
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload: hold while the input register is stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_data <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    slncp_fsm #(
        .VALUE_BITS (VALUE_BITS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_data   (r_in_data),
        .i_last   (r_in_last),
        .o_emit   (w_emit),
        .o_letter (w_letter),
        .o_value  (w_value),
        .o_ovf    (w_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out_letter <= w_letter;
            r_out_value  <= w_value;
            r_out_ovf    <= w_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_BITS'({r_out_value, r_out_letter});
    assign o_m_tuser  = r_out_ovf;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_data))
        else $error("stalled input item lost");

    a_no_step_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_step)
        else $error("result produced without a processed item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed before it was taken");

endmodule
